// File: rtl/core/rlw_pkg.sv
// Shared types and constants of the recursive lock with FIFO waiters.
// Used by the queue cells, the core and the port checker; no dependencies.
package rlw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 4;
  localparam int unsigned COUNT_BITS_DEF  = 8;
  localparam int unsigned NEST_W          = 8;
  localparam int unsigned STATUS_W        = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED         = 3'd0,
    ST_QUEUED          = 3'd1,
    ST_RELEASED        = 3'd2,
    ST_NOT_HOLDER      = 3'd3,
    ST_ALREADY_WAITING = 3'd4,
    ST_QUEUE_FULL      = 3'd5,
    ST_COUNT_OVERFLOW  = 3'd6
  } status_e;

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef struct packed {
    logic cmp;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/core/recursive_lock_with_fifo_waiters_core.sv
// Top level of the recursive lock with a FIFO of waiting thread ids.
// Holds the lock state and a chain of rlw_cell queue cells; uses rlw_pkg.
//
// channel   direction  handshake               word
// request   in         start_i while !busy_o   kind_i, thread_id_i
// result    out        done_o, one cycle       status_o, wake_valid_o,
//                                              wake_thread_o, nest_count_o
//
// For each request, the accept edge has every cell compare its id with the
// requester, and the next edge combines the cell hits and updates the lock,
// the queue and the result registers. done_o is high in the cycle after
// busy_o, and a new request may be accepted in that same cycle.
// Reset clears the lock state and the fill count; no clearing pass is run.
// The receiver cannot stall; a result is shown for one cycle only.
module recursive_lock_with_fifo_waiters_core #(
  parameter int unsigned QUEUE_DEPTH = rlw_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = rlw_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rlw_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [ID_BITS-1:0]           thread_id_i,
  output logic                         done_o,
  output logic [rlw_pkg::STATUS_W-1:0] status_o,
  output logic                         wake_valid_o,
  output logic [ID_BITS-1:0]           wake_thread_o,
  output logic [rlw_pkg::NEST_W-1:0]   nest_count_o
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic                  accept;
  logic                  busy_q;
  logic                  kind_q;
  logic [ID_BITS-1:0]    tid_q;
  logic [ID_BITS-1:0]    tid_cell;
  logic                  free_q, free_d;
  logic [ID_BITS-1:0]    holder_q, holder_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  push, pop, any_hit;
  rlw_pkg::status_e      status_d;
  logic                  wake_d;
  logic [ID_BITS-1:0]    wake_thread_d;
  logic [rlw_pkg::NEST_W+COUNT_BITS-1:0] nest_ext;

  logic                  done_q;
  logic [rlw_pkg::STATUS_W-1:0] status_q;
  logic                  wake_q;
  logic [ID_BITS-1:0]    wake_thread_q;
  logic [rlw_pkg::NEST_W-1:0] nest_q;

  rlw_pkg::cell_ctl_t    ctl;
  logic [ID_BITS-1:0]    cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_hit;

  assign accept    = start_i && !busy_q;
  assign tid_cell  = accept ? thread_id_i : tid_q;
  assign ctl.cmp   = accept;
  assign ctl.shift = pop;
  assign any_hit   = |cell_hit;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] next_id;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_id = cell_id[i];
    end else begin : g_mid
      assign next_id = cell_id[i+1];
    end
    rlw_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .occ_i    (fill_q > FILL_W'(i)),
      .push_i   (push && (fill_q == FILL_W'(i))),
      .tid_i    (tid_cell),
      .next_id_i(next_id),
      .id_o     (cell_id[i]),
      .hit_o    (cell_hit[i])
    );
  end

  always_comb begin
    free_d        = free_q;
    holder_d      = holder_q;
    count_d       = count_q;
    fill_d        = fill_q;
    push          = 1'b0;
    pop           = 1'b0;
    wake_d        = 1'b0;
    wake_thread_d = '0;
    status_d      = rlw_pkg::ST_GRANTED;
    if (busy_q) begin
      if (kind_q == rlw_pkg::KIND_ACQUIRE) begin
        if (!free_q && (holder_q == tid_q)) begin
          if (count_q == COUNT_MAX) begin
            status_d = rlw_pkg::ST_COUNT_OVERFLOW;
          end else begin
            count_d = count_q + COUNT_ONE;
          end
        end else if (free_q) begin
          free_d   = 1'b0;
          holder_d = tid_q;
          count_d  = COUNT_ONE;
        end else if (any_hit) begin
          status_d = rlw_pkg::ST_ALREADY_WAITING;
        end else if (fill_q == FILL_FULL) begin
          status_d = rlw_pkg::ST_QUEUE_FULL;
        end else begin
          push     = 1'b1;
          fill_d   = fill_q + FILL_W'(1);
          status_d = rlw_pkg::ST_QUEUED;
        end
      end else begin
        if (free_q || (holder_q != tid_q)) begin
          status_d = rlw_pkg::ST_NOT_HOLDER;
        end else if (count_q > COUNT_ONE) begin
          count_d  = count_q - COUNT_ONE;
          status_d = rlw_pkg::ST_RELEASED;
        end else begin
          free_d   = 1'b1;
          holder_d = '0;
          count_d  = '0;
          status_d = rlw_pkg::ST_RELEASED;
          if (fill_q != '0) begin
            pop           = 1'b1;
            wake_d        = 1'b1;
            wake_thread_d = cell_id[0];
            fill_d        = fill_q - FILL_W'(1);
          end
        end
      end
    end
  end

  assign nest_ext = {{rlw_pkg::NEST_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      free_q   <= 1'b1;
      holder_q <= '0;
      count_q  <= '0;
      fill_q   <= '0;
    end else begin
      busy_q   <= accept;
      done_q   <= busy_q;
      free_q   <= free_d;
      holder_q <= holder_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      tid_q  <= thread_id_i;
    end
    if (busy_q) begin
      status_q      <= status_d;
      wake_q        <= wake_d;
      wake_thread_q <= wake_thread_d;
      nest_q        <= nest_ext[rlw_pkg::NEST_W-1:0];
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign wake_valid_o  = wake_q;
  assign wake_thread_o = wake_thread_q;
  assign nest_count_o  = nest_q;

endmodule

// File: rtl/core/rlw_cell.sv
// One wait-queue cell: holds one waiting thread id, compares it with the
// requester and hands its id toward the head on a pop. Depends on rlw_pkg.
module rlw_cell #(
  parameter int unsigned ID_BITS = rlw_pkg::ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlw_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               push_i,
  input  logic [ID_BITS-1:0] tid_i,
  input  logic [ID_BITS-1:0] next_id_i,
  output logic [ID_BITS-1:0] id_o,
  output logic               hit_o
);

  logic [ID_BITS-1:0] id_q, id_d;
  logic               hit_q, hit_d;

  always_comb begin
    id_d = id_q;
    if (push_i) begin
      id_d = tid_i;
    end else if (ctl_i.shift) begin
      id_d = next_id_i;
    end
  end

  assign hit_d = ctl_i.cmp ? (occ_i && (id_q == tid_i)) : hit_q;

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign id_o  = id_q;
  assign hit_o = hit_q;

endmodule

// File: rtl/core/rlw_checker.sv
// Port-level checker for the recursive lock core, bound to the top level.
// Depends on rlw_pkg and recursive_lock_with_fifo_waiters_core.
module rlw_checker #(
  parameter int unsigned ID_BITS = rlw_pkg::ID_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [rlw_pkg::STATUS_W-1:0] status_o,
  input logic                         wake_valid_o,
  input logic [ID_BITS-1:0]           wake_thread_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("result word did not follow busy cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result word without a request");

  a_wake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !wake_valid_o |-> wake_thread_o == '0)
    else $error("wake thread nonzero without wake");

  a_wake_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && wake_valid_o |-> status_o == rlw_pkg::ST_RELEASED)
    else $error("wake outside a final release");

endmodule

bind recursive_lock_with_fifo_waiters_core rlw_checker #(
  .ID_BITS(ID_BITS)
) u_rlw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .status_o     (status_o),
  .wake_valid_o (wake_valid_o),
  .wake_thread_o(wake_thread_o)
);
